[hdl/b32d_pkg.sv]
`default_nettype none

package b32d_pkg;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_TRAIL,
    PH_FAIL
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_QUANTUM  = 3'd1,
    ST_MISSING_PAD  = 3'd2,
    ST_BAD_PAD_CHAR = 3'd3,
    ST_TRAILING     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ALPHABET = 2'd0,
    CFG_PADDING  = 2'd1,
    CFG_TRAILING = 2'd2
  } cfg_index_e;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [7:0] CHAR_PAD    = 8'h3D;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] decoded_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic alphabet_select;
    logic pad_required;
    logic forbid_trailing;
  } cfg_t;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  bits_held;
    logic [2:0]  quantum_symbols;
    phase_e      phase;
    logic [2:0]  padding_left;
    status_e     error_code;
    logic [15:0] byte_count;
  } msg_state_t;

  localparam cfg_t CFG_RESET = '{
    alphabet_select: 1'b0,
    pad_required:    1'b1,
    forbid_trailing: 1'b0
  };

  localparam msg_state_t MSG_STATE_RESET = '{
    acc:             12'd0,
    bits_held:       4'd0,
    quantum_symbols: 3'd0,
    phase:           PH_DATA,
    padding_left:    3'd0,
    error_code:      ST_OK,
    byte_count:      16'd0
  };

  // Bit 5 flags a character of the alphabet, bits 4:0 hold its symbol value.
  function automatic logic [5:0] lookup_symbol(input logic alt, input logic [7:0] c);
    logic [7:0] d;
    logic       v;
    d = 8'd0;
    v = 1'b0;
    if (alt) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        v = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h56) begin
        d = c - 8'h41 + 8'd10;
        v = 1'b1;
      end
    end else begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        v = 1'b1;
      end else if (c >= 8'h32 && c <= 8'h37) begin
        d = c - 8'h32 + 8'd26;
        v = 1'b1;
      end
    end
    return {v, d[4:0]};
  endfunction

  // Padding needed after a final quantum; bit 3 set means the length is invalid.
  function automatic logic [3:0] pad_needed(input logic [2:0] q);
    logic [3:0] p;
    unique case (q)
      3'd0:    p = 4'd0;
      3'd2:    p = 4'd6;
      3'd4:    p = 4'd4;
      3'd5:    p = 4'd3;
      3'd7:    p = 4'd1;
      default: p = 4'd8;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[hdl/base32_stream_decoder_unit.sv]
`default_nettype none

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-----------------------------
// in       | input     | in_valid_i / in_stall_o  | in_item_t (char, end flag)
// out      | output    | out_valid_o / out_stall_i| out_item_t (byte or status)
// cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item a cycle is taken unless stalled; a result passes the item register, then the queue.
// The item register feeds a single pass of lookup and bit packing into a four-item queue.
// An item yields at most a byte and an end status; the queue drains one a cycle unless stalled.
// The item register stalls while the queue has room for fewer than two items.
// Reset clears the message state, the queue and sets the registers to their defaults.

module base32_stream_decoder_unit import b32d_pkg::*; (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output logic           in_stall_o,
  input  var in_item_t   in_item_i,
  output logic           out_valid_o,
  input  var logic       out_stall_i,
  output out_item_t      out_item_o,
  input  var logic       cfg_valid_i,
  output logic           cfg_ready_o,
  input  var logic [1:0] cfg_index_i,
  input  var logic       cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  msg_state_t st_q;
  msg_state_t st_next;
  in_item_t   in_q;
  logic       in_valid_q;
  logic       room;
  logic       fire;
  logic       accept;
  logic       byte_valid;
  out_item_t  byte_item;
  logic       status_valid;
  out_item_t  status_item;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && room;
  assign in_stall_o  = in_valid_q && !room;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALPHABET: cfg_d.alphabet_select = cfg_data_i;
        CFG_PADDING:  cfg_d.pad_required    = cfg_data_i;
        CFG_TRAILING: cfg_d.forbid_trailing = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= CFG_RESET;
      st_q       <= MSG_STATE_RESET;
      in_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (fire) begin
        st_q <= st_next;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  b32d_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (st_q),
    .item_i         (in_q),
    .state_o        (st_next),
    .byte_valid_o   (byte_valid),
    .byte_item_o    (byte_item),
    .status_valid_o (status_valid),
    .status_item_o  (status_item)
  );

  b32d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (fire && byte_valid),
    .item_a_i    (byte_item),
    .push_b_i    (fire && status_valid),
    .item_b_i    (status_item),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.end_of_text) |=> (st_q.phase == PH_DATA && st_q.byte_count == 16'd0))
    else $error("message state not cleared after the last item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind == KIND_DATA) |->
      (out_item_o.status == 3'd0 && !out_item_o.last && out_item_o.decoded_count == 16'd0))
    else $error("data item carries status fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_DATA) |-> (st_q.bits_held <= 4'd7))
    else $error("bit accumulator holds a whole byte");

endmodule

`default_nettype wire

[hdl/b32d_step.sv]
`default_nettype none

module b32d_step import b32d_pkg::*; (
  input  var cfg_t       cfg_i,
  input  var msg_state_t state_i,
  input  var in_item_t   item_i,
  output msg_state_t     state_o,
  output logic           byte_valid_o,
  output out_item_t      byte_item_o,
  output logic           status_valid_o,
  output out_item_t      status_item_o
);

  logic [5:0]  lk;
  logic [3:0]  pn;
  logic [3:0]  pn_end;
  logic [11:0] acc_new;
  logic [3:0]  bits_new;
  logic [2:0]  rem;
  logic [11:0] shifted;
  logic [11:0] mask;
  logic        is_pad;
  msg_state_t  ns;
  status_e     end_code;

  always_comb begin
    lk       = lookup_symbol(cfg_i.alphabet_select, item_i.char_code);
    pn       = pad_needed(state_i.quantum_symbols);
    acc_new  = {state_i.acc[6:0], lk[4:0]};
    bits_new = state_i.bits_held + 4'd5;
    rem      = 3'(bits_new - 4'd8);
    shifted  = acc_new >> rem;
    mask     = (12'd1 << rem) - 12'd1;
    is_pad   = (item_i.char_code == CHAR_PAD);

    ns            = state_i;
    byte_valid_o  = 1'b0;
    byte_item_o   = '0;
    byte_item_o.kind = KIND_DATA;

    unique case (state_i.phase)
      PH_DATA: begin
        if (lk[5]) begin
          ns.acc             = acc_new;
          ns.bits_held       = bits_new;
          ns.quantum_symbols = state_i.quantum_symbols + 3'd1;
          if (bits_new >= 4'd8) begin
            ns.acc       = acc_new & mask;
            ns.bits_held = {1'b0, rem};
            if (state_i.byte_count != COUNT_MAX) begin
              ns.byte_count = state_i.byte_count + 16'd1;
            end
            byte_valid_o          = 1'b1;
            byte_item_o.data_byte = shifted[7:0];
          end
        end else begin
          ns.acc       = 12'd0;
          ns.bits_held = 4'd0;
          if (pn[3]) begin
            ns.phase      = PH_FAIL;
            ns.error_code = ST_BAD_QUANTUM;
          end else if (cfg_i.pad_required && pn != 4'd0) begin
            ns.phase = PH_PAD;
            if (is_pad) begin
              ns.padding_left = pn[2:0] - 3'd1;
              if (pn[2:0] == 3'd1) begin
                ns.phase = PH_TRAIL;
              end
            end else begin
              ns.padding_left = pn[2:0];
              ns.phase        = PH_FAIL;
              ns.error_code   = ST_BAD_PAD_CHAR;
            end
          end else begin
            ns.phase = PH_TRAIL;
            if (cfg_i.forbid_trailing) begin
              ns.phase      = PH_FAIL;
              ns.error_code = ST_TRAILING;
            end
          end
        end
      end
      PH_PAD: begin
        if (is_pad) begin
          ns.padding_left = state_i.padding_left - 3'd1;
          if (state_i.padding_left == 3'd1) begin
            ns.phase = PH_TRAIL;
          end
        end else begin
          ns.phase      = PH_FAIL;
          ns.error_code = ST_BAD_PAD_CHAR;
        end
      end
      PH_TRAIL: begin
        if (cfg_i.forbid_trailing) begin
          ns.phase      = PH_FAIL;
          ns.error_code = ST_TRAILING;
        end
      end
      PH_FAIL: begin
        ns.phase = PH_FAIL;
      end
    endcase

    pn_end   = pad_needed(ns.quantum_symbols);
    end_code = ns.error_code;
    if (ns.phase == PH_DATA) begin
      if (pn_end[3]) begin
        end_code = ST_BAD_QUANTUM;
      end else if (cfg_i.pad_required && pn_end != 4'd0) begin
        end_code = ST_MISSING_PAD;
      end
    end else if (ns.phase == PH_PAD && ns.padding_left != 3'd0) begin
      end_code = ST_MISSING_PAD;
    end

    status_valid_o              = item_i.end_of_text;
    status_item_o               = '0;
    status_item_o.kind          = KIND_STATUS;
    status_item_o.status        = end_code;
    status_item_o.decoded_count = ns.byte_count;
    status_item_o.last          = 1'b1;

    state_o = item_i.end_of_text ? MSG_STATE_RESET : ns;
  end

endmodule

`default_nettype wire

[hdl/b32d_outq.sv]
`default_nettype none

module b32d_outq import b32d_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      push_a_i,
  input  var out_item_t item_a_i,
  input  var logic      push_b_i,
  input  var out_item_t item_b_i,
  output logic          room_o,
  output logic          out_valid_o,
  output out_item_t     out_item_o,
  input  var logic      out_stall_i
);

  out_item_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d;
  logic [QPTR_W-1:0]  rd_q, rd_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic [QPTR_W-1:0]  wr_b;
  logic               pop;

  assign room_o      = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = entry_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_b        = wr_q + QPTR_W'(push_a_i);

  always_comb begin
    wr_d    = wr_q + QPTR_W'(push_a_i) + QPTR_W'(push_b_i);
    rd_d    = rd_q + QPTR_W'(pop);
    count_d = count_q + QCNT_W'(push_a_i) + QCNT_W'(push_b_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      entry_q[wr_q] <= item_a_i;
    end
    if (push_b_i) begin
      entry_q[wr_b] <= item_b_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue count beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a_i || push_b_i) |-> room_o)
    else $error("output queue written without room for two items");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output item changed");

endmodule

`default_nettype wire

[tb/base32_checker.sv]
`timescale 1ns / 1ps

module base32_checker import b32d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_o
);

  localparam int unsigned NO_SYMBOL  = 32;
  localparam int unsigned BAD_LENGTH = 8;

  cfg_t        regs;
  logic [11:0] acc_bits;
  logic [3:0]  held;
  logic [2:0]  quantum;
  phase_e      ph;
  logic [2:0]  pads_due;
  status_e     first_err;
  logic [15:0] bytes_out;

  out_item_t decoded_q[$];
  int        mismatches;
  int        results_seen;

  function automatic int unsigned symbol_value(input logic hex, input logic [7:0] c);
    if (hex) begin
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "V") return c - "A" + 10;
    end else begin
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "2" && c <= "7") return c - "2" + 26;
    end
    return NO_SYMBOL;
  endfunction

  function automatic int unsigned padding_for(input logic [2:0] q);
    case (q)
      3'd0:    return 0;
      3'd2:    return 6;
      3'd4:    return 4;
      3'd5:    return 3;
      3'd7:    return 1;
      default: return BAD_LENGTH;
    endcase
  endfunction

  task automatic clear_message();
    acc_bits  = '0;
    held      = '0;
    quantum   = '0;
    ph        = PH_DATA;
    pads_due  = '0;
    first_err = ST_OK;
    bytes_out = '0;
  endtask

  task automatic abort_message(input status_e code);
    first_err = code;
    ph        = PH_FAIL;
  endtask

  task automatic take_padding(input logic [7:0] c);
    if (c == CHAR_PAD) begin
      pads_due = pads_due - 3'd1;
      if (pads_due == 3'd0) ph = PH_TRAIL;
    end else begin
      abort_message(ST_BAD_PAD_CHAR);
    end
  endtask

  task automatic decode_char(input in_item_t it);
    int unsigned sym;
    int unsigned need;
    logic [3:0]  rem;
    out_item_t   r;
    case (ph)
      PH_DATA: begin
        sym = symbol_value(regs.alphabet_select, it.char_code);
        if (sym < NO_SYMBOL) begin
          acc_bits = {acc_bits[6:0], sym[4:0]};
          held     = held + 4'd5;
          quantum  = quantum + 3'd1;
          if (held >= 4'd8) begin
            rem         = held - 4'd8;
            r           = '0;
            r.kind      = KIND_DATA;
            r.data_byte = 8'(acc_bits >> rem);
            acc_bits    = acc_bits & ((12'd1 << rem) - 12'd1);
            held        = rem;
            if (bytes_out != COUNT_MAX) bytes_out = bytes_out + 16'd1;
            decoded_q.push_back(r);
          end
        end else begin
          need     = padding_for(quantum);
          acc_bits = '0;
          held     = '0;
          if (need == BAD_LENGTH) begin
            abort_message(ST_BAD_QUANTUM);
          end else if (regs.pad_required && need != 0) begin
            ph       = PH_PAD;
            pads_due = 3'(need);
            take_padding(it.char_code);
          end else begin
            ph = PH_TRAIL;
            if (regs.forbid_trailing) abort_message(ST_TRAILING);
          end
        end
      end
      PH_PAD: take_padding(it.char_code);
      PH_TRAIL: begin
        if (regs.forbid_trailing) abort_message(ST_TRAILING);
      end
      default: ;
    endcase
    if (it.end_of_text) begin
      if (ph == PH_DATA) begin
        need = padding_for(quantum);
        if (need == BAD_LENGTH) abort_message(ST_BAD_QUANTUM);
        else if (regs.pad_required && need != 0) abort_message(ST_MISSING_PAD);
      end else if (ph == PH_PAD && pads_due != 3'd0) begin
        abort_message(ST_MISSING_PAD);
      end
      r               = '0;
      r.kind          = KIND_STATUS;
      r.status        = first_err;
      r.decoded_count = bytes_out;
      r.last          = 1'b1;
      decoded_q.push_back(r);
      clear_message();
    end
  endtask

  function automatic int field_differs(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, actual %0h", name, want, got);
    return 1;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    int        bad;
    results_seen++;
    if (decoded_q.size() == 0) begin
      $error("result %h arrived with nothing outstanding", got);
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      bad  = field_differs("kind", 16'(want.kind), 16'(got.kind))
           + field_differs("data_byte", 16'(want.data_byte), 16'(got.data_byte))
           + field_differs("status", 16'(want.status), 16'(got.status))
           + field_differs("decoded_count", want.decoded_count, got.decoded_count)
           + field_differs("last", 16'(want.last), 16'(got.last));
      if (bad != 0) mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = CFG_RESET;
      clear_message();
      decoded_q.delete();
      mismatches   = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ALPHABET: regs.alphabet_select = cfg_data_i;
          CFG_PADDING:  regs.pad_required    = cfg_data_i;
          CFG_TRAILING: regs.forbid_trailing = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) decode_char(in_item_i);
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      fail_count_o <= mismatches;
      pending_o    <= decoded_q.size();
      results_o    <= results_seen;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import b32d_pkg::*;

  localparam int          RANDOM_ITEMS  = 1830;
  localparam int          CALM_ITEMS    = 250;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 300;
  localparam logic [1:0]  CFG_UNUSED    = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall_o;
  in_item_t   in_item;
  logic       out_valid_o;
  logic       out_stall;
  out_item_t  out_item_o;
  logic       cfg_valid;
  logic       cfg_ready_o;
  logic [1:0] cfg_index;
  logic       cfg_data;

  int fail_count;
  int pending;
  int results;

  bit         idle_on = 1'b1;
  bit         long_hold_req = 1'b0;
  logic       use_hex, want_pad, trail_banned;
  logic [7:0] text_q[$];
  int         chars_sent, random_items, messages, settings_done;

  base32_stream_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  base32_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd200_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] symbol_char(input logic hex, input logic [4:0] s);
    if (hex) return (s < 5'd10) ? "0" + {3'b0, s} : "A" + {3'b0, s} - 8'd10;
    return (s < 5'd26) ? "A" + {3'b0, s} : "2" + {3'b0, s} - 8'd26;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eot);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{char_code: c, end_of_text: eot};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    messages++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ALPHABET: use_hex      = v;
      CFG_PADDING:  want_pad     = v;
      CFG_TRAILING: trail_banned = v;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic a, input logic p, input logic t);
    set_register(CFG_ALPHABET, a);
    set_register(CFG_PADDING, p);
    set_register(CFG_TRAILING, t);
    settings_done++;
  endtask

  // Mostly legal final quanta with the padding they call for; now and then an arbitrary pair.
  task automatic pick_quantum(output int nsym, output int npad);
    case ($urandom_range(0, 4))
      0: begin nsym = 0; npad = 0; end
      1: begin nsym = 2; npad = 6; end
      2: begin nsym = 4; npad = 4; end
      3: begin nsym = 5; npad = 3; end
      default: begin nsym = 7; npad = 1; end
    endcase
    nsym += 8 * $urandom_range(0, 2);
    if ($urandom_range(0, 6) == 0) begin
      nsym = $urandom_range(0, 23);
      npad = $urandom_range(0, 7);
    end
    if (!want_pad && $urandom_range(0, 3) != 0) npad = 0;
  endtask

  task automatic build_message();
    int nsym, npad, pos;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick_quantum(nsym, npad);
      repeat (nsym) text_q.push_back(symbol_char(use_hex, 5'($urandom_range(0, 31))));
      if (nsym > 0 && $urandom_range(0, 9) == 0) begin
        pos = $urandom_range(0, nsym - 1);
        text_q.insert(pos, 8'($urandom_range(0, 255)));
      end
      repeat (npad) text_q.push_back(CHAR_PAD);
      if (npad > 0 && $urandom_range(0, 6) == 0)
        text_q[text_q.size() - 1 - $urandom_range(0, npad - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, trail_banned ? 4 : 2) == 0)
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_message();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    random_items += text_q.size();
    messages++;
  endtask

  initial begin
    int phase_no;
    int k;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ALPHABET;
    cfg_data  <= 1'b0;
    rst_ni    <= 1'b0;
    use_hex      = CFG_RESET.alphabet_select;
    want_pad     = CFG_RESET.pad_required;
    trail_banned = CFG_RESET.forbid_trailing;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_string("A7");
    send_string("MY======");
    send_string("ABC");
    send_char("A", 1'b0);
    send_char("B", 1'b0);
    send_char(CHAR_PAD, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    messages += 2;
    quiesce();
    set_all(1'b1, 1'b0, 1'b1);
    set_register(CFG_UNUSED, 1'b1);
    send_string("0V=");
    send_string("W");

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiesce();
      case (phase_no)
        0: set_all(1'b1, 1'b1, 1'b1);
        1: set_all(1'b0, 1'b0, 1'b0);
        default: set_all($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      if (phase_no == 2) long_hold_req = 1'b1;
      repeat ($urandom_range(8, 20)) begin
        if (random_items >= RANDOM_ITEMS) break;
        build_message();
        send_message();
        if (random_items > RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    for (k = 0; k < 5000 && pending != 0; k++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d characters in %0d messages over %0d register settings.",
             chars_sent, messages, settings_done);
    $display("Compared %0d results, %0d mismatched, %0d still outstanding.",
             results, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[base32_stream_decoder_unit.f]
hdl/b32d_pkg.sv
hdl/b32d_step.sv
hdl/b32d_outq.sv
hdl/base32_stream_decoder_unit.sv
tb/base32_checker.sv
tb/testbench.sv
